// File: design/sfd_pkg.sv
// ----------------------------------------------------------------------------
// sfd_pkg
// shared types, constants and the crc-16 byte update for the serial deframer
// ----------------------------------------------------------------------------
package sfd_pkg;

   localparam int unsigned LEN_W = 10;

   localparam logic [7:0]  FLAG_BYTE   = 8'h7E;
   localparam logic [7:0]  ESC_BYTE    = 8'h7D;
   localparam logic [7:0]  UNSTUFF_ADD = 8'h20;
   localparam logic [7:0]  ESC_ESC     = ESC_BYTE - UNSTUFF_ADD;
   localparam logic [7:0]  ESC_FLAG    = FLAG_BYTE - UNSTUFF_ADD;
   localparam logic [15:0] CRC_INIT    = 16'hFFFF;
   localparam logic [15:0] CRC_POLY    = 16'h8408;
   localparam logic [LEN_W-1:0] MIN_BODY   = LEN_W'(9);
   localparam logic [LEN_W-1:0] HDR_FCS    = LEN_W'(4);
   localparam logic [LEN_W-1:0] DELAY_FULL = LEN_W'(2);

   typedef enum logic [1:0] {
      MODE_HUNT = 2'd0,
      MODE_BODY = 2'd1,
      MODE_ESC  = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      ST_GOOD     = 3'd0,
      ST_SHORT    = 3'd1,
      ST_COUNT    = 3'd2,
      ST_FCS      = 3'd3,
      ST_OVERFLOW = 3'd4,
      ST_BADESC   = 3'd5,
      ST_FLAGESC  = 3'd6
   } status_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] payload_byte;
      logic       byte_present;
      logic       frame_end;
      status_type frame_status;
   } result_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// File: design/sfd_engine.sv
// ----------------------------------------------------------------------------
// sfd_engine
// deframing state machine: flag hunt, unstuffing, crc, delay line and checks
// ----------------------------------------------------------------------------
module sfd_engine #(
   parameter int unsigned MAX_FRAME_BYTES = 550
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               fire,
   input  logic [7:0]         rx_byte,
   output sfd_pkg::result_type result
);
   import sfd_pkg::*;

   mode_type         mode_ff, mode_in;
   logic [LEN_W-1:0] body_length_ff, body_length_in;
   logic [15:0]      crc_ff, crc_in;
   logic [7:0]       delay0_ff, delay0_in;
   logic [7:0]       delay1_ff, delay1_in;
   logic [7:0]       count_ff, count_in;

   logic             is_flag, is_esc, is_unstuff;
   logic             store;
   logic [7:0]       store_data;
   logic [LEN_W-1:0] len_plus;
   logic             overflow;
   status_type       check_status;

   assign is_flag    = (rx_byte == FLAG_BYTE);
   assign is_esc     = (rx_byte == ESC_BYTE);
   assign is_unstuff = (rx_byte == ESC_ESC) || (rx_byte == ESC_FLAG);
   assign store      = ((mode_ff == MODE_BODY) && !is_flag && !is_esc)
                    || ((mode_ff == MODE_ESC) && is_unstuff);
   assign store_data = (mode_ff == MODE_ESC) ? (rx_byte + UNSTUFF_ADD) : rx_byte;
   assign len_plus   = body_length_ff + LEN_W'(1);
   assign overflow   = (len_plus >= LEN_W'(MAX_FRAME_BYTES));

   always_comb begin
      if (body_length_ff < MIN_BODY) begin
         check_status = ST_SHORT;
      end else if ({{(LEN_W-8){1'b0}}, count_ff} != (body_length_ff - HDR_FCS)) begin
         check_status = ST_COUNT;
      end else if ({delay0_ff, delay1_ff} != crc_ff) begin
         check_status = ST_FCS;
      end else begin
         check_status = ST_GOOD;
      end
   end

   // next state
   always_comb begin
      mode_in = mode_ff;
      if (fire) begin
         case (mode_ff)
            MODE_BODY: begin
               if (is_esc) begin
                  mode_in = MODE_ESC;
               end else if (is_flag) begin
                  mode_in = (check_status == ST_GOOD) ? MODE_HUNT : MODE_BODY;
               end else begin
                  mode_in = overflow ? MODE_HUNT : MODE_BODY;
               end
            end
            MODE_ESC: begin
               if (is_unstuff) begin
                  mode_in = overflow ? MODE_HUNT : MODE_BODY;
               end else if (is_flag) begin
                  mode_in = MODE_BODY;
               end else begin
                  mode_in = MODE_HUNT;
               end
            end
            default: begin
               mode_in = is_flag ? MODE_BODY : MODE_HUNT;
            end
         endcase
      end
   end

   // datapath and result
   always_comb begin
      body_length_in = body_length_ff;
      crc_in         = crc_ff;
      delay0_in      = delay0_ff;
      delay1_in      = delay1_ff;
      count_in       = count_ff;
      result         = '0;
      if (fire) begin
         if (store) begin
            if (body_length_ff >= DELAY_FULL) begin
               crc_in    = crc_byte(crc_ff, delay0_ff);
               delay0_in = delay1_ff;
               delay1_in = store_data;
            end else begin
               if (!body_length_ff[0]) begin
                  delay0_in = store_data;
               end else begin
                  delay1_in = store_data;
                  count_in  = store_data;
               end
            end
            body_length_in = len_plus;
            if (overflow) begin
               result.valid        = 1'b1;
               result.frame_end    = 1'b1;
               result.frame_status = ST_OVERFLOW;
            end else if (body_length_ff >= HDR_FCS) begin
               result.valid        = 1'b1;
               result.byte_present = 1'b1;
               result.payload_byte = delay0_ff;
            end
         end else begin
            case (mode_ff)
               MODE_BODY: begin
                  if (is_flag) begin
                     result.valid        = 1'b1;
                     result.frame_end    = 1'b1;
                     result.frame_status = check_status;
                     body_length_in      = '0;
                     crc_in              = CRC_INIT;
                  end
               end
               MODE_ESC: begin
                  result.valid     = 1'b1;
                  result.frame_end = 1'b1;
                  if (is_flag) begin
                     result.frame_status = ST_FLAGESC;
                     body_length_in      = '0;
                     crc_in              = CRC_INIT;
                  end else begin
                     result.frame_status = ST_BADESC;
                  end
               end
               default: begin
                  if (is_flag) begin
                     body_length_in = '0;
                     crc_in         = CRC_INIT;
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_HUNT;
         body_length_ff <= '0;
         crc_ff         <= CRC_INIT;
      end else begin
         mode_ff        <= mode_in;
         body_length_ff <= body_length_in;
         crc_ff         <= crc_in;
      end
   end

   always_ff @(posedge clock) begin
      delay0_ff <= delay0_in;
      delay1_ff <= delay1_in;
      count_ff  <= count_in;
   end

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      (mode_ff != MODE_HUNT) |-> (body_length_ff < LEN_W'(MAX_FRAME_BYTES)))
      else $error("body length reached limit without overflow");

   a_ovf_hunt: assert property (@(posedge clock) disable iff (reset)
      (fire && result.frame_status == ST_OVERFLOW) |=> (mode_ff == MODE_HUNT))
      else $error("overflow did not return to hunt");

   a_end_no_data: assert property (@(posedge clock) disable iff (reset)
      result.frame_end |-> (!result.byte_present && result.valid))
      else $error("frame end beat carries data");

endmodule

// File: design/serial_frame_deframer_fcs16_core.sv
// ----------------------------------------------------------------------------
// serial_frame_deframer_fcs16_core
// byte-stuffed flag-framed deframer with crc-16 check and status per frame
// ----------------------------------------------------------------------------
//  channel  direction  ports
//  req      in         req_valid, req_stall, req_rx_byte
//  rsp      out        rsp_valid, rsp_stall, rsp_payload_byte, rsp_byte_present,
//                      rsp_frame_end, rsp_frame_status
//
//  one byte per cycle sustained while rsp_stall is low; a byte is captured in the
//  input register and its result is registered in the output register
//  the crc byte update and the deframing machine sit between the two registers
//  synchronous reset puts the machine in flag hunt with the crc at all ones
//  rsp_stall holds the output register; req_stall rises only when both
//  registers are full and the output is stalled
module serial_frame_deframer_fcs16_core #(
   parameter int unsigned MAX_FRAME_BYTES = 550
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_payload_byte,
   output logic       rsp_byte_present,
   output logic       rsp_frame_end,
   output logic [2:0] rsp_frame_status
);
   import sfd_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       advance, fire;
   result_type result;
   result_type out_ff, out_in;

   assign advance   = !out_ff.valid || !rsp_stall;
   assign fire      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   assign in_valid_in = req_stall ? in_valid_ff : req_valid;
   assign out_in      = advance ? result : out_ff;

   sfd_engine #(
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .rx_byte(in_byte_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_ff.valid <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_ff      <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   assign rsp_valid        = out_ff.valid;
   assign rsp_payload_byte = out_ff.payload_byte;
   assign rsp_byte_present = out_ff.byte_present;
   assign rsp_frame_end    = out_ff.frame_end;
   assign rsp_frame_status = out_ff.frame_status;

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// testbench for the byte-stuffed flag-framed deframer with crc-16 check
// ----------------------------------------------------------------------------
// drives raw line bytes into the deframer with random gaps and stalls, keeps a
// behavioral copy of the hunt/body/escape machine, the crc-16 and the two-byte
// delay line, and checks every output beat field by field in arrival order;
// directed tests cover noise, a good frame, each error status and overflow,
// then mostly well-formed random frames with injected faults
module tb_top;
   import sfd_pkg::*;

   localparam int MAX_FRAME_BYTES = 550;
   localparam int TOTAL_ITEMS     = 1050;

   typedef struct packed {
      logic [7:0] data;
      logic       present;
      logic       frame_end;
      status_type status;
   } beat_type;

   logic       clock;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_stall;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall   = 1'b0;
   logic [7:0] rsp_payload_byte;
   logic       rsp_byte_present;
   logic       rsp_frame_end;
   logic [2:0] rsp_frame_status;

   // deframer state as predicted
   mode_type   rx_state   = MODE_HUNT;
   logic [9:0] body_len   = '0;
   logic [15:0] fcs_acc   = CRC_INIT;
   logic [7:0] pipe_q [2] = '{8'h00, 8'h00};
   logic [7:0] count_byte = 8'h00;

   beat_type   pending_beats[$];
   logic [7:0] frame_payload[$];
   logic [7:0] frame_body[$];
   beat_type   due;
   bit         steady     = 1'b0;
   int         hold_cnt   = 0;
   int         items_sent = 0;
   int         mismatches = 0;

   serial_frame_deframer_fcs16_core #(
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_byte_present (rsp_byte_present),
      .rsp_frame_end    (rsp_frame_end),
      .rsp_frame_status (rsp_frame_status)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   function automatic logic [15:0] fcs16_next(input logic [15:0] acc, input logic [7:0] d);
      logic [15:0] r;
      r = acc;
      for (int i = 0; i < 8; i++) begin
         r = (r >> 1) ^ ((r[0] ^ d[i]) ? CRC_POLY : 16'h0000);
      end
      return r;
   endfunction

   function automatic status_type frame_verdict();
      if (body_len < MIN_BODY) begin
         return ST_SHORT;
      end
      if ({2'b00, count_byte} != body_len - HDR_FCS) begin
         return ST_COUNT;
      end
      if ({pipe_q[0], pipe_q[1]} != fcs_acc) begin
         return ST_FCS;
      end
      return ST_GOOD;
   endfunction

   task automatic push_beat(input logic [7:0] d, input logic p, input logic e,
                            input status_type s);
      beat_type bt;
      bt.data      = d;
      bt.present   = p;
      bt.frame_end = e;
      bt.status    = s;
      pending_beats = {pending_beats, bt};
   endtask

   task automatic open_body();
      rx_state = MODE_BODY;
      body_len = '0;
      fcs_acc  = CRC_INIT;
   endtask

   task automatic store_body_byte(input logic [7:0] b);
      logic [7:0] leaving;
      logic       emit;
      leaving = 8'h00;
      emit    = 1'b0;
      if (body_len >= DELAY_FULL) begin
         leaving   = pipe_q[0];
         fcs_acc   = fcs16_next(fcs_acc, leaving);
         emit      = (body_len >= HDR_FCS);
         pipe_q[0] = pipe_q[1];
         pipe_q[1] = b;
      end else begin
         pipe_q[body_len[0]] = b;
         if (body_len == 10'd1) begin
            count_byte = b;
         end
      end
      body_len = body_len + 10'd1;
      if (body_len >= MAX_FRAME_BYTES) begin
         rx_state = MODE_HUNT;
         push_beat(8'h00, 1'b0, 1'b1, ST_OVERFLOW);
      end else if (emit) begin
         push_beat(leaving, 1'b1, 1'b0, ST_GOOD);
      end
   endtask

   task automatic deframe_byte(input logic [7:0] b);
      status_type st;
      case (rx_state)
         MODE_BODY: begin
            if (b == ESC_BYTE) begin
               rx_state = MODE_ESC;
            end else if (b == FLAG_BYTE) begin
               st = frame_verdict();
               if (st == ST_GOOD) begin
                  rx_state = MODE_HUNT;
               end else begin
                  open_body();
               end
               push_beat(8'h00, 1'b0, 1'b1, st);
            end else begin
               store_body_byte(b);
            end
         end
         MODE_ESC: begin
            if (b == ESC_ESC || b == ESC_FLAG) begin
               rx_state = MODE_BODY;
               store_body_byte(b + UNSTUFF_ADD);
            end else if (b == FLAG_BYTE) begin
               open_body();
               push_beat(8'h00, 1'b0, 1'b1, ST_FLAGESC);
            end else begin
               rx_state = MODE_HUNT;
               push_beat(8'h00, 1'b0, 1'b1, ST_BADESC);
            end
         end
         default: begin
            if (b == FLAG_BYTE) begin
               open_body();
            end else begin
               rx_state = MODE_HUNT;
            end
         end
      endcase
   endtask

   // output side: check each beat, then draw the next stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_beats.size() == 0) begin
            $error("rsp beat with nothing expected");
            mismatches++;
         end else begin
            due = pending_beats.pop_front();
            if (rsp_payload_byte !== due.data) begin
               $error("rsp_payload_byte: expected %0h, got %0h", due.data, rsp_payload_byte);
               mismatches++;
            end
            if (rsp_byte_present !== due.present) begin
               $error("rsp_byte_present: expected %0d, got %0d", due.present,
                      rsp_byte_present);
               mismatches++;
            end
            if (rsp_frame_end !== due.frame_end) begin
               $error("rsp_frame_end: expected %0d, got %0d", due.frame_end, rsp_frame_end);
               mismatches++;
            end
            if (rsp_frame_status !== due.status) begin
               $error("rsp_frame_status: expected %0d, got %0d", due.status,
                      rsp_frame_status);
               mismatches++;
            end
         end
         hold_cnt = steady ? 0 : $urandom_range(0, 6);
      end else if (hold_cnt != 0) begin
         hold_cnt--;
      end
      rsp_stall <= (hold_cnt != 0);
   end

   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      deframe_byte(b);
      items_sent++;
   endtask

   function automatic logic [7:0] line_data();
      if ($urandom_range(0, 7) == 0) begin
         return $urandom_range(0, 1) ? ESC_BYTE : FLAG_BYTE;
      end
      return 8'($urandom_range(0, 255));
   endfunction

   // body = revision, count, payload, fcs high, fcs low
   task automatic build_frame(input logic [7:0] rev, input logic [7:0] count_err,
                              input logic [15:0] fcs_err);
      logic [15:0] c;
      frame_body.delete();
      frame_body = {rev, 8'(frame_payload.size()) ^ count_err};
      frame_body = {frame_body, frame_payload};
      c = CRC_INIT;
      foreach (frame_body[i]) c = fcs16_next(c, frame_body[i]);
      c = c ^ fcs_err;
      frame_body = {frame_body, c[15:8], c[7:0]};
   endtask

   task automatic send_stuffed(input int cut, input int mark_at, input logic [7:0] mark_byte,
                               input bit close);
      logic [7:0] b;
      send_byte(FLAG_BYTE);
      for (int i = 0; i < frame_body.size() - cut; i++) begin
         if (i == mark_at) begin
            send_byte(ESC_BYTE);
            send_byte(mark_byte);
         end
         b = frame_body[i];
         if (b == FLAG_BYTE || b == ESC_BYTE) begin
            send_byte(ESC_BYTE);
            send_byte(b - UNSTUFF_ADD);
         end else begin
            send_byte(b);
         end
      end
      if (close) begin
         send_byte(FLAG_BYTE);
      end
   endtask

   task automatic test_hunt_noise();
      send_byte(8'h00);
      send_byte(8'hFF);
   endtask

   task automatic test_good_frame();
      frame_payload = '{FLAG_BYTE, 8'h00, 8'hFF, ESC_BYTE, 8'h5E};
      build_frame(8'h01, 8'h00, 16'h0000);
      send_stuffed(0, -1, 8'h00, 1'b1);
   endtask

   task automatic test_error_frames();
      // empty body, flag after escape, bad escape
      send_byte(FLAG_BYTE);
      send_byte(FLAG_BYTE);
      send_byte(ESC_BYTE);
      send_byte(FLAG_BYTE);
      send_byte(ESC_BYTE);
      send_byte(8'h41);
      frame_payload = '{8'h11, 8'h22, 8'h33, 8'h44, 8'h55};
      build_frame(8'hFF, 8'h01, 16'h0000);
      send_stuffed(0, -1, 8'h00, 1'b1);
      build_frame(8'h00, 8'h00, 16'h8000);
      send_stuffed(0, -1, 8'h00, 1'b1);
   endtask

   task automatic test_overflow();
      logic [7:0] b;
      send_byte(FLAG_BYTE);
      while (rx_state != MODE_HUNT) begin
         if ($urandom_range(0, 15) == 0) begin
            send_byte(ESC_BYTE);
            send_byte($urandom_range(0, 1) ? ESC_ESC : ESC_FLAG);
         end else begin
            do b = 8'($urandom_range(0, 255)); while (b == FLAG_BYTE || b == ESC_BYTE);
            send_byte(b);
         end
      end
      send_byte(8'h5D);
   endtask

   task automatic test_random();
      int stop_at;
      int kind;
      int plen;
      int cut;
      int mark_at;
      logic [7:0] mark_byte;
      logic [7:0] count_err;
      logic [15:0] fcs_err;
      stop_at = TOTAL_ITEMS;
      while (items_sent < stop_at) begin
         steady    = ($urandom_range(0, 4) == 0);
         kind      = $urandom_range(0, 99);
         plen      = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255)
                                                  : $urandom_range(0, 12);
         count_err = 8'h00;
         fcs_err   = 16'h0000;
         cut       = 0;
         mark_at   = -1;
         mark_byte = FLAG_BYTE;
         frame_payload.delete();
         repeat (plen) frame_payload = {frame_payload, line_data()};
         if (kind >= 70 && kind < 78) begin
            count_err = 8'($urandom_range(1, 255));
         end else if (kind >= 78 && kind < 86) begin
            fcs_err = 16'h0001 << $urandom_range(0, 15);
         end else if (kind >= 86 && kind < 90) begin
            cut = $urandom_range(1, 3);
         end
         build_frame(8'($urandom_range(0, 255)), count_err, fcs_err);
         if (kind >= 90 && kind < 97) begin
            mark_at = $urandom_range(0, frame_body.size() - 1);
            if (kind < 94) begin
               do mark_byte = 8'($urandom_range(0, 255));
               while (mark_byte == ESC_ESC || mark_byte == ESC_FLAG || mark_byte == FLAG_BYTE);
            end
         end
         send_stuffed(cut, mark_at, mark_byte, kind < 97);
         if (kind >= 97) begin
            repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)));
         end
      end
      steady = 1'b0;
   endtask

   task automatic finish_run();
      req_valid <= 1'b0;
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_hunt_noise();
      test_good_frame();
      test_error_frames();
      test_overflow();
      test_random();
      finish_run();
   end

endmodule
